@@ rtl/core/rfrf_pkg.sv @@
// ----------------------------------------------------------------------------
// Radio frame receive filter package
// Shared codes, header constants and the result record.
// ----------------------------------------------------------------------------
package rfrf_pkg;

  // header layout
  localparam int unsigned HDR_LEN = 6;
  localparam logic [7:0]  MAGIC_A = 8'h53;  // 'S'
  localparam logic [7:0]  MAGIC_B = 8'h52;  // 'R'
  localparam logic [10:0] PLEN_SAT = 11'h7FF;

  // verdict codes
  localparam logic [3:0] ST_DELIVER    = 4'd0;
  localparam logic [3:0] ST_SHORT      = 4'd1;
  localparam logic [3:0] ST_BAD_MAGIC  = 4'd2;
  localparam logic [3:0] ST_LEN_MISM   = 4'd3;
  localparam logic [3:0] ST_BAD_TYPE   = 4'd4;
  localparam logic [3:0] ST_OTHER_GRP  = 4'd5;
  localparam logic [3:0] ST_REPEAT     = 4'd6;
  localparam logic [3:0] ST_NO_HANDLER = 4'd7;
  localparam logic [3:0] ST_BAD_PLEN   = 4'd8;
  localparam logic [3:0] ST_OVERSIZE   = 4'd9;

  // data types
  localparam logic [1:0] TYPE_NUMBER = 2'd1;
  localparam logic [1:0] TYPE_KEYVAL = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_OWN_GROUP    = 2'd0;
  localparam logic [1:0] CFG_DROP_REPEATS = 2'd1;
  localparam logic [1:0] CFG_HANDLER_EN   = 2'd2;

  typedef struct packed {
    logic [3:0]        status;
    logic [7:0]        frame_group;
    logic [1:0]        data_type;
    logic [10:0]       body_len;
    logic [47:0]       sender;
    logic signed [7:0] signal;
  } result_t;

endpackage

@@ rtl/core/rfrf_store.sv @@
// ----------------------------------------------------------------------------
// Radio frame receive filter frame store
// Two byte memories, one per half; both read at one address, one written.
// ----------------------------------------------------------------------------
module rfrf_store #(
  parameter int unsigned MAX_FRAME = 2048,
  localparam int unsigned AW = $clog2(MAX_FRAME)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic          wr_half_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  output logic [7:0]    rd0_o,
  output logic [7:0]    rd1_o
);

  logic [7:0] mem0 [MAX_FRAME];
  logic [7:0] mem1 [MAX_FRAME];
  logic [7:0] rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_half_i) begin
      mem0[wr_addr_i] <= wr_data_i;
    end
    if (wr_en_i && wr_half_i) begin
      mem1[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd0_q <= mem0[rd_addr_i];
      rd1_q <= mem1[rd_addr_i];
    end
  end

  assign rd0_o = rd0_q;
  assign rd1_o = rd1_q;

endmodule

@@ rtl/core/rfrf_check.sv @@
// ----------------------------------------------------------------------------
// Radio frame receive filter check stage
// Byte compare against the kept frame, header capture and frame verdict.
// ----------------------------------------------------------------------------
module rfrf_check #(
  parameter int unsigned MAX_FRAME = 2048,
  localparam int unsigned CW = $clog2(MAX_FRAME + 2)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic [CW-1:0]       pos_i,
  input  logic [47:0]         src_i,
  input  logic signed [7:0]   rssi_i,
  input  logic [7:0]          rd0_i,
  input  logic [7:0]          rd1_i,
  input  logic [7:0]          own_group_i,
  input  logic                drop_repeats_i,
  input  logic [3:0]          handler_en_i,
  output logic                wr_en_o,
  output logic                wr_half_o,
  output rfrf_pkg::result_t   result_o
);

  localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAME);
  localparam logic [CW-1:0] HDR_C = CW'(rfrf_pkg::HDR_LEN);

  logic [7:0]    hdr_q [rfrf_pkg::HDR_LEN];
  logic [7:0]    hdr   [rfrf_pkg::HDR_LEN];
  logic          same_q;
  logic          stored_v_q;
  logic [CW-1:0] stored_len_q;
  logic [47:0]   stored_src_q;
  logic          half_q;

  logic          in_store;
  logic [7:0]    keep_byte;
  logic          same_eff;
  logic [CW-1:0] cnt;
  logic [15:0]   len16;
  logic [7:0]    typ;
  logic          do_store;
  rfrf_pkg::result_t res;

  assign in_store  = pos_i < MAX_C;
  assign keep_byte = half_q ? rd1_i : rd0_i;
  assign same_eff  = same_q &&
                     !(stored_v_q && pos_i < stored_len_q && in_store && keep_byte != byte_i);
  assign cnt       = (pos_i <= MAX_C) ? pos_i + CW'(1) : pos_i;

  // header with the current byte merged in
  always_comb begin
    for (int i = 0; i < rfrf_pkg::HDR_LEN; i++) begin
      hdr[i] = (pos_i == CW'(i)) ? byte_i : hdr_q[i];
    end
  end

  assign len16 = {hdr[5], hdr[4]};
  assign typ   = hdr[3];

  always_comb begin
    res             = '0;
    res.sender      = src_i;
    res.signal      = rssi_i;
    do_store        = 1'b0;
    if (cnt < HDR_C) begin
      res.status = rfrf_pkg::ST_SHORT;
    end else if (hdr[0] != rfrf_pkg::MAGIC_A || hdr[1] != rfrf_pkg::MAGIC_B) begin
      res.status = rfrf_pkg::ST_BAD_MAGIC;
    end else if (cnt > MAX_C) begin
      res.status = rfrf_pkg::ST_OVERSIZE;
    end else begin
      res.frame_group = hdr[2];
      res.data_type   = (typ <= 8'd3) ? typ[1:0] : 2'd0;
      res.body_len    = (len16 > 16'd2047) ? rfrf_pkg::PLEN_SAT : len16[10:0];
      if (17'(cnt) != {1'b0, len16} + 17'd6) begin
        res.status = rfrf_pkg::ST_LEN_MISM;
      end else if (typ > 8'd3) begin
        res.status = rfrf_pkg::ST_BAD_TYPE;
      end else if (hdr[2] != own_group_i) begin
        res.status = rfrf_pkg::ST_OTHER_GRP;
      end else if (drop_repeats_i && stored_v_q && stored_len_q == cnt &&
                   stored_src_q == src_i && same_eff) begin
        res.status = rfrf_pkg::ST_REPEAT;
      end else begin
        do_store = 1'b1;
        if (!handler_en_i[typ[1:0]]) begin
          res.status = rfrf_pkg::ST_NO_HANDLER;
        end else if (typ[1:0] == rfrf_pkg::TYPE_NUMBER && len16 != 16'd8) begin
          res.status = rfrf_pkg::ST_BAD_PLEN;
        end else if (typ[1:0] == rfrf_pkg::TYPE_KEYVAL && len16 < 16'd8) begin
          res.status = rfrf_pkg::ST_BAD_PLEN;
        end else begin
          res.status = rfrf_pkg::ST_DELIVER;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rfrf_pkg::HDR_LEN; i++) begin
        hdr_q[i] <= '0;
      end
      same_q       <= 1'b1;
      stored_v_q   <= 1'b0;
      stored_len_q <= '0;
      stored_src_q <= '0;
      half_q       <= 1'b0;
    end else if (fire_i) begin
      if (last_i) begin
        for (int i = 0; i < rfrf_pkg::HDR_LEN; i++) begin
          hdr_q[i] <= '0;
        end
        same_q <= 1'b1;
        if (do_store) begin
          half_q       <= ~half_q;
          stored_v_q   <= 1'b1;
          stored_len_q <= cnt;
          stored_src_q <= src_i;
        end
      end else begin
        for (int i = 0; i < rfrf_pkg::HDR_LEN; i++) begin
          hdr_q[i] <= hdr[i];
        end
        same_q <= same_eff;
      end
    end
  end

  // byte goes to the fill half, the one not kept
  assign wr_en_o   = fire_i && in_store;
  assign wr_half_o = ~half_q;
  assign result_o  = res;

endmodule

@@ rtl/core/radio_frame_receive_filter_core.sv @@
// ----------------------------------------------------------------------------
// Radio frame receive filter
// Checks a received frame byte by byte and gives one verdict at its end.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Beat
// -------   ---------  ---------------------  ---------------------------------
// in        sink       in_valid_i/in_stall_o  one frame byte, last flag, source,
//                                             signal strength
// out       source     out_valid_o/out_stall_i one verdict per frame
// cfg       sink       cfg_we_i               own group, repeat drop, handlers
//
// Throughput: one byte per cycle while in_stall_o is low. Two stages: the accept
// edge reads both store halves at the byte position, and the compare stage then
// compares, writes the byte to the fill half and, for a last byte, forms the
// verdict into the output register.
// in_stall_o rises only while a last byte waits in the compare stage and the
// output register holds an unaccepted verdict under out_stall_i.
// Reset clears control state only; the store needs no clearing pass since a
// kept frame's bytes are always written before they are compared.
//
module radio_frame_receive_filter_core #(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic [47:0]       src_addr_i,
  input  logic signed [7:0] rssi_i,
  // config write
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  // verdict output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        status_o,
  output logic [7:0]        frame_group_o,
  output logic [1:0]        data_type_o,
  output logic [10:0]       body_len_o,
  output logic [47:0]       sender_o,
  output logic signed [7:0] signal_o
);

  localparam int unsigned  CW    = $clog2(MAX_FRAME + 2);
  localparam int unsigned  AW    = $clog2(MAX_FRAME);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAME);

  // config registers
  logic [7:0] own_group_q;
  logic       drop_repeats_q;
  logic [3:0] handler_en_q;

  // byte position, saturating at MAX_FRAME+1
  logic [CW-1:0] count_q, count_d;

  // read stage
  logic              s1_v_q;
  logic [7:0]        s1_byte_q;
  logic              s1_last_q;
  logic [CW-1:0]     s1_pos_q;
  logic [47:0]       s1_src_q;
  logic signed [7:0] s1_rssi_q;

  // output register
  logic              out_v_q;
  rfrf_pkg::result_t out_q;

  logic              s1_hold, accept, fire;
  logic              wr_en, wr_half;
  logic [7:0]        rd0, rd1;
  rfrf_pkg::result_t result;

  // a last byte cannot leave the compare stage while the verdict slot is blocked
  assign s1_hold    = s1_v_q && s1_last_q && out_v_q && out_stall_i;
  assign in_stall_o = s1_hold;
  assign accept     = in_valid_i && !s1_hold;
  assign fire       = s1_v_q && !s1_hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_group_q    <= 8'd0;
      drop_repeats_q <= 1'b1;
      handler_en_q   <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rfrf_pkg::CFG_OWN_GROUP:    own_group_q    <= cfg_data_i;
        rfrf_pkg::CFG_DROP_REPEATS: drop_repeats_q <= cfg_data_i[0];
        rfrf_pkg::CFG_HANDLER_EN:   handler_en_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (last_byte_i) begin
        count_d = '0;
      end else if (count_q <= MAX_C) begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      s1_v_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (fire) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
      s1_pos_q  <= count_q;
      s1_src_q  <= src_addr_i;
      s1_rssi_q <= rssi_i;
    end
  end

  rfrf_store #(
    .MAX_FRAME (MAX_FRAME)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept && count_q < MAX_C),
    .rd_addr_i (count_q[AW-1:0]),
    .wr_en_i   (wr_en),
    .wr_half_i (wr_half),
    .wr_addr_i (s1_pos_q[AW-1:0]),
    .wr_data_i (s1_byte_q),
    .rd0_o     (rd0),
    .rd1_o     (rd1)
  );

  rfrf_check #(
    .MAX_FRAME (MAX_FRAME)
  ) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .byte_i         (s1_byte_q),
    .last_i         (s1_last_q),
    .pos_i          (s1_pos_q),
    .src_i          (s1_src_q),
    .rssi_i         (s1_rssi_q),
    .rd0_i          (rd0),
    .rd1_i          (rd1),
    .own_group_i    (own_group_q),
    .drop_repeats_i (drop_repeats_q),
    .handler_en_i   (handler_en_q),
    .wr_en_o        (wr_en),
    .wr_half_o      (wr_half),
    .result_o       (result)
  );

  // verdict register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fire && s1_last_q) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && s1_last_q) begin
      out_q <= result;
    end
  end

  assign out_valid_o   = out_v_q;
  assign status_o      = out_q.status;
  assign frame_group_o = out_q.frame_group;
  assign data_type_o   = out_q.data_type;
  assign body_len_o    = out_q.body_len;
  assign sender_o      = out_q.sender;
  assign signal_o      = out_q.signal;

endmodule
